// ----- hw/rtl/dpmm_pkg.sv -----
// Package: shared constants, types and codes of the demand-paged memory manager.
package dpmm_pkg;

    localparam int NUM_FRAMES        = 16;
    localparam int FRAME_BYTES       = 64;
    localparam int NUM_PROCESSES     = 16;
    localparam int PAGES_PER_PROCESS = 16;

    localparam int WORDS_PER_FRAME = FRAME_BYTES / 2;
    localparam int FRAME_W  = $clog2(NUM_FRAMES);
    localparam int PROC_W   = $clog2(NUM_PROCESSES);
    localparam int PAGE_W   = $clog2(PAGES_PER_PROCESS);
    localparam int OFF_W    = $clog2(WORDS_PER_FRAME);
    localparam int PTE_W    = PROC_W + PAGE_W;
    localparam int PTE_DEPTH = NUM_PROCESSES * PAGES_PER_PROCESS;
    localparam int PHYS_DEPTH = NUM_FRAMES * WORDS_PER_FRAME;
    localparam int BACK_DEPTH = PTE_DEPTH * WORDS_PER_FRAME;
    localparam int PHYS_AW  = $clog2(PHYS_DEPTH);
    localparam int BACK_AW  = $clog2(BACK_DEPTH);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_VIOLATE  = 2'd1,
        ST_TOOLARGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,     // clear the page table after reset, one entry a cycle
        S_IDLE,
        S_CLR,      // clear page entries of a process, one page a cycle
        S_ZERO,     // zero backing pages after allocate, one word a cycle
        S_LOOK,     // page entry read valid
        S_SCAN,     // search free frame, one frame a cycle
        S_WBACK,    // copy victim frame out, one word a cycle
        S_LOAD,     // copy backing page in, one word a cycle
        S_ACC,      // issue the word access
        S_ACCW,     // read data valid
        S_OUT
    } state_t;

    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [FRAME_W-1:0]  frame;
    } pte_t;

    typedef struct packed {
        logic                valid;
        logic [PROC_W-1:0]   proc;
        logic [PAGE_W-1:0]   page;
    } fown_t;

    // Copy engine command and status between sequencer and copy unit.
    typedef struct packed {
        logic               start;
        logic [1:0]         mode;   // CP_ZERO, CP_OUT, CP_IN
        logic [FRAME_W-1:0] frame;
        logic [PTE_W-1:0]   bpage;
    } cp_cmd_t;

    localparam logic [1:0] CP_ZERO = 2'd0;
    localparam logic [1:0] CP_OUT  = 2'd1;
    localparam logic [1:0] CP_IN   = 2'd2;

endpackage

// ----- hw/rtl/dpmm_ram.sv -----
// Generic single-port-write, registered-read RAM.
module dpmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/dpmm_copy.sv -----
// Word copy unit: zeroes a backing page, or moves a page between frame and backing store.
module dpmm_copy import dpmm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cp_cmd_t             cmd,
    output logic                busy,
    output logic                done,
    // physical store access
    output logic                ph_we,
    output logic [PHYS_AW-1:0]  ph_waddr,
    output logic [15:0]         ph_wdata,
    output logic [PHYS_AW-1:0]  ph_raddr,
    input  logic [15:0]         ph_rdata,
    // backing store access
    output logic                bk_we,
    output logic [BACK_AW-1:0]  bk_waddr,
    output logic [15:0]         bk_wdata,
    output logic [BACK_AW-1:0]  bk_raddr,
    input  logic [15:0]         bk_rdata
);
    logic               run_reg, run_next;
    logic [1:0]         mode_reg, mode_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [PTE_W-1:0]   bpage_reg, bpage_next;
    logic [OFF_W:0]     rcnt_reg, rcnt_next;   // read pointer, one ahead
    logic               wv_reg, wv_next;       // write stage valid
    logic [OFF_W-1:0]   wcnt_reg, wcnt_next;

    // Sequence reads and delayed writes
    always_comb begin
        run_next   = run_reg;
        mode_next  = mode_reg;
        frame_next = frame_reg;
        bpage_next = bpage_reg;
        rcnt_next  = rcnt_reg;
        wv_next    = 1'b0;
        wcnt_next  = rcnt_reg[OFF_W-1:0];
        done       = run_reg && (rcnt_reg == (OFF_W+1)'(WORDS_PER_FRAME));
        if (run_reg) begin
            if (done) begin
                run_next = 1'b0;
            end else begin
                rcnt_next = rcnt_reg + 1'b1;
                wv_next   = 1'b1;
            end
        end
        // Take a new command, also in the cycle that ends the previous copy
        if (cmd.start) begin
            run_next   = 1'b1;
            mode_next  = cmd.mode;
            frame_next = cmd.frame;
            bpage_next = cmd.bpage;
            rcnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            wv_reg  <= 1'b0;
        end else begin
            run_reg <= run_next;
            wv_reg  <= wv_next;
        end
        mode_reg  <= mode_next;
        frame_reg <= frame_next;
        bpage_reg <= bpage_next;
        rcnt_reg  <= rcnt_next;
        wcnt_reg  <= wcnt_next;
    end

    assign busy     = run_reg;
    assign ph_raddr = PHYS_AW'({frame_reg, rcnt_reg[OFF_W-1:0]});
    assign bk_raddr = BACK_AW'({bpage_reg, rcnt_reg[OFF_W-1:0]});
    assign ph_we    = wv_reg && (mode_reg == CP_IN);
    assign ph_waddr = PHYS_AW'({frame_reg, wcnt_reg});
    assign ph_wdata = bk_rdata;
    assign bk_we    = wv_reg && (mode_reg != CP_IN);
    assign bk_waddr = BACK_AW'({bpage_reg, wcnt_reg});
    assign bk_wdata = (mode_reg == CP_ZERO) ? 16'd0 : ph_rdata;

`ifndef SYNTH
    // A finished copy writes its last word in the done cycle
    a_done_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> wv_reg)
        else $error("copy done without trailing write");
    // No write outside a run
    a_write_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        wv_reg |-> $past(run_reg))
        else $error("copy write outside run");
    // Start is only issued while idle or as the running copy ends
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> (!run_reg || done))
        else $error("copy started while busy");
`endif
endmodule

// ----- hw/rtl/demand_paged_memory_manager.sv -----
// Top level: command sequencer, page/frame tables and word stores of the paged memory manager.
// Processing: a rejected item or a free of an idle process goes straight to the result; a free
// clears the process's page entries; an allocate clears them and then zeroes each page granted;
// a read or write hit accesses the frame directly; a fault searches for the first free frame
// (frame 0 is the victim when all are taken) and copies the page in, after writing back a dirty victim.
// One item at a time: ready only when idle, so a new item is taken only after the result is accepted.
// Reset: synchronous active-low; frame and process tables clear at once, the page table in a
// pass over all PTE_DEPTH entries with ready low; word stores undefined until written.
module demand_paged_memory_manager import dpmm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [3:0]  s_process_id,
    input  logic [15:0] s_byte_address,
    input  logic [15:0] s_write_word,
    input  logic [10:0] s_request_bytes,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_read_word,
    output logic [1:0]  m_status,
    output logic        m_fault_taken,
    output logic        m_victim_written_back,
    output logic [3:0]  m_frame_used,
    output logic [4:0]  m_pages_granted,
    output logic [15:0] m_paged_in_total,
    output logic [15:0] m_paged_out_total
);
    localparam int NPG_W = $clog2(PAGES_PER_PROCESS + 1);
    localparam int SZ_W  = 11;

    state_t state_reg, state_next;

    // Small tables in flip-flops, reset at once
    fown_t fown_reg [NUM_FRAMES];
    logic  act_reg  [NUM_PROCESSES];
    logic [SZ_W-1:0] size_reg [NUM_PROCESSES];

    // Page table store access
    logic               pte_we;
    logic [PTE_W-1:0]   pte_wa, pte_ra;
    pte_t               pte_wd, pte_rd;
    logic [PTE_W-1:0]   icnt_reg, icnt_next;

    // Item registers
    op_t              op_reg;
    logic [PROC_W-1:0] pid_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [15:0]       wval_reg;
    logic [NPG_W-1:0]  npg_reg;
    logic [PAGE_W:0]   cnt_reg, cnt_next;
    logic [FRAME_W:0]  fcnt_reg, fcnt_next;
    logic [FRAME_W-1:0] fr_reg, fr_next;

    // Result registers
    logic [15:0] rword_reg, rword_next;
    status_t     stat_reg, stat_next;
    logic        fault_reg, fault_next;
    logic        wb_reg, wb_next;
    logic [NPG_W-1:0] gr_reg, gr_next;
    logic [15:0] pin_reg, pout_reg;

    cp_cmd_t cmd;
    logic    cp_busy, cp_done;
    logic    cp_ph_we, cp_bk_we;
    logic [PHYS_AW-1:0] cp_ph_wa, cp_ph_ra;
    logic [BACK_AW-1:0] cp_bk_wa, cp_bk_ra;
    logic [15:0] cp_ph_wd, cp_bk_wd, ph_rdata, bk_rdata;

    logic               ph_we;
    logic [PHYS_AW-1:0] ph_wa, ph_ra;
    logic [15:0]        ph_wd;

    // Decode of the incoming item
    logic [SZ_W:0]     req_up;
    logic [SZ_W:0]     in_npg_full;
    logic              in_big;
    logic [NPG_W-1:0]  in_npg;
    logic [15:0]       in_page_full;
    logic [OFF_W-1:0]  in_off;
    assign req_up       = {1'b0, s_request_bytes} + (SZ_W+1)'(FRAME_BYTES - 1);
    assign in_npg_full  = (SZ_W+1)'(req_up / FRAME_BYTES);
    assign in_big       = in_npg_full > (SZ_W+1)'(PAGES_PER_PROCESS);
    assign in_npg       = NPG_W'(in_npg_full);
    assign in_page_full = 16'(s_byte_address / FRAME_BYTES);
    assign in_off       = OFF_W'((s_byte_address % FRAME_BYTES) / 2);

    logic [PTE_W-1:0] cur_pte_idx;
    assign cur_pte_idx = PTE_W'({pid_reg, page_reg});

    logic [PTE_W-1:0] victim_idx;
    assign victim_idx = PTE_W'({fown_reg[0].proc, fown_reg[0].page});

    logic pte_load_we, victim_clr;
    logic fown_set, fown_pclr;

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        icnt_next   = icnt_reg;
        cnt_next    = cnt_reg;
        fcnt_next   = fcnt_reg;
        fr_next     = fr_reg;
        rword_next  = rword_reg;
        stat_next   = stat_reg;
        fault_next  = fault_reg;
        wb_next     = wb_reg;
        gr_next     = gr_reg;
        cmd         = '0;
        pte_we      = 1'b0;
        pte_wa      = cur_pte_idx;
        pte_wd      = '0;
        pte_ra      = cur_pte_idx;
        pte_load_we = 1'b0;
        victim_clr  = 1'b0;
        fown_set    = 1'b0;
        fown_pclr   = 1'b0;
        ph_we       = 1'b0;
        ph_wa       = cp_ph_wa;
        ph_wd       = cp_ph_wd;
        ph_ra       = cp_ph_ra;
        case (state_reg)
            S_INIT: begin
                // Invalidate one page entry a cycle
                pte_we    = 1'b1;
                pte_wa    = icnt_reg;
                icnt_next = icnt_reg + 1'b1;
                if (icnt_reg == PTE_W'(PTE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                // Read the addressed page entry as the item is taken
                pte_ra = PTE_W'({s_process_id, PAGE_W'(in_page_full)});
                if (s_valid) begin
                    rword_next = '0;
                    stat_next  = ST_OK;
                    fault_next = 1'b0;
                    wb_next    = 1'b0;
                    gr_next    = '0;
                    cnt_next   = '0;
                    case (op_t'(s_operation))
                        OP_ALLOC: begin
                            if (in_big) begin
                                stat_next  = ST_TOOLARGE;
                                state_next = S_OUT;
                            end else begin
                                state_next = S_CLR;
                            end
                        end
                        OP_FREE: begin
                            state_next = act_reg[PROC_W'(s_process_id)] ? S_CLR : S_OUT;
                        end
                        default: begin
                            if (!act_reg[PROC_W'(s_process_id)] ||
                                s_byte_address >= 16'(size_reg[PROC_W'(s_process_id)]) ||
                                in_page_full >= 16'(PAGES_PER_PROCESS)) begin
                                stat_next  = ST_VIOLATE;
                                state_next = S_OUT;
                            end else begin
                                state_next = S_LOOK;
                            end
                        end
                    endcase
                end
            end
            S_CLR: begin
                // Release the process's frames with the first entry, clear one page entry a cycle
                fown_pclr  = (cnt_reg == '0);
                pte_we     = 1'b1;
                pte_wa     = PTE_W'({pid_reg, PAGE_W'(cnt_reg)});
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == (PAGE_W+1)'(PAGES_PER_PROCESS - 1)) begin
                    cnt_next = '0;
                    if (op_reg == OP_ALLOC) begin
                        gr_next    = npg_reg;
                        state_next = (npg_reg == '0) ? S_OUT : S_ZERO;
                        cmd.start  = (npg_reg != '0);
                        cmd.mode   = CP_ZERO;
                        cmd.bpage  = PTE_W'({pid_reg, {PAGE_W{1'b0}}});
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_ZERO: begin
                if (cp_done) begin
                    cnt_next = cnt_reg + 1'b1;
                    if ((cnt_reg + 1'b1) == (PAGE_W+1)'(npg_reg)) begin
                        state_next = S_OUT;
                    end else begin
                        cmd.start = 1'b1;
                        cmd.mode  = CP_ZERO;
                        cmd.bpage = PTE_W'({pid_reg, PAGE_W'(cnt_reg + 1'b1)});
                    end
                end
            end
            S_LOOK: begin
                if (pte_rd.valid) begin
                    fr_next    = pte_rd.frame;
                    state_next = S_ACC;
                end else begin
                    fault_next = 1'b1;
                    fcnt_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // Look at one frame per cycle for the first free one, else evict frame 0; keep the victim entry read
                pte_ra = victim_idx;
                if (fcnt_reg == (FRAME_W+1)'(NUM_FRAMES)) begin
                    fr_next    = '0;
                    victim_clr = 1'b1;
                    pte_we     = 1'b1;
                    pte_wa     = victim_idx;
                    if (pte_rd.dirty) begin
                        wb_next    = 1'b1;
                        cmd.start  = 1'b1;
                        cmd.mode   = CP_OUT;
                        cmd.frame  = '0;
                        cmd.bpage  = victim_idx;
                        state_next = S_WBACK;
                    end else begin
                        cmd.start  = 1'b1;
                        cmd.mode   = CP_IN;
                        cmd.frame  = '0;
                        cmd.bpage  = cur_pte_idx;
                        state_next = S_LOAD;
                    end
                end else if (!fown_reg[FRAME_W'(fcnt_reg)].valid) begin
                    fr_next    = FRAME_W'(fcnt_reg);
                    cmd.start  = 1'b1;
                    cmd.mode   = CP_IN;
                    cmd.frame  = FRAME_W'(fcnt_reg);
                    cmd.bpage  = cur_pte_idx;
                    state_next = S_LOAD;
                end else begin
                    fcnt_next = fcnt_reg + 1'b1;
                end
            end
            S_WBACK: begin
                if (cp_done) begin
                    cmd.start  = 1'b1;
                    cmd.mode   = CP_IN;
                    cmd.frame  = fr_reg;
                    cmd.bpage  = cur_pte_idx;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                ph_we = cp_ph_we;
                if (cp_done) begin
                    pte_load_we = 1'b1;
                    pte_we      = 1'b1;
                    pte_wd      = '{valid: 1'b1, dirty: 1'b0, frame: fr_reg};
                    fown_set    = 1'b1;
                    state_next  = S_ACC;
                end
            end
            S_ACC: begin
                ph_ra = PHYS_AW'({fr_reg, off_reg});
                ph_wa = PHYS_AW'({fr_reg, off_reg});
                ph_wd = wval_reg;
                if (op_reg == OP_WRITE) begin
                    ph_we      = 1'b1;
                    pte_we     = 1'b1;
                    pte_wd     = '{valid: 1'b1, dirty: 1'b1, frame: fr_reg};
                    state_next = S_OUT;
                end else begin
                    state_next = S_ACCW;
                end
            end
            S_ACCW: begin
                rword_next = ph_rdata;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            icnt_reg  <= '0;
            pin_reg   <= '0;
            pout_reg  <= '0;
            for (int i = 0; i < NUM_FRAMES; i++) begin
                fown_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_PROCESSES; i++) begin
                act_reg[i]  <= 1'b0;
                size_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            icnt_reg  <= icnt_next;
            if (state_reg == S_IDLE && s_valid && op_t'(s_operation) == OP_ALLOC &&
                !in_big) begin
                act_reg[PROC_W'(s_process_id)]  <= 1'b1;
                size_reg[PROC_W'(s_process_id)] <= s_request_bytes;
            end
            if (state_reg == S_IDLE && s_valid && op_t'(s_operation) == OP_FREE) begin
                act_reg[PROC_W'(s_process_id)]  <= 1'b0;
                size_reg[PROC_W'(s_process_id)] <= '0;
            end
            if (fown_pclr) begin
                for (int i = 0; i < NUM_FRAMES; i++) begin
                    if (fown_reg[i].proc == pid_reg) begin
                        fown_reg[i].valid <= 1'b0;
                    end
                end
            end
            if (victim_clr) begin
                fown_reg[0].valid <= 1'b0;
                if (pte_rd.dirty && pout_reg != 16'hFFFF) begin
                    pout_reg <= pout_reg + 1'b1;
                end
            end
            if (pte_load_we) begin
                if (pin_reg != 16'hFFFF) begin
                    pin_reg <= pin_reg + 1'b1;
                end
            end
            if (fown_set) begin
                fown_reg[fr_reg] <= '{valid: 1'b1, proc: pid_reg, page: page_reg};
            end
        end
    end

    // Item and result payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            op_reg   <= op_t'(s_operation);
            pid_reg  <= PROC_W'(s_process_id);
            page_reg <= PAGE_W'(in_page_full);
            off_reg  <= in_off;
            wval_reg <= s_write_word;
            npg_reg  <= in_npg;
        end
        cnt_reg   <= cnt_next;
        fcnt_reg  <= fcnt_next;
        fr_reg    <= fr_next;
        rword_reg <= rword_next;
        stat_reg  <= stat_next;
        fault_reg <= fault_next;
        wb_reg    <= wb_next;
        gr_reg    <= gr_next;
    end

    dpmm_copy u_copy (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .busy     (cp_busy),
        .done     (cp_done),
        .ph_we    (cp_ph_we),
        .ph_waddr (cp_ph_wa),
        .ph_wdata (cp_ph_wd),
        .ph_raddr (cp_ph_ra),
        .ph_rdata (ph_rdata),
        .bk_we    (cp_bk_we),
        .bk_waddr (cp_bk_wa),
        .bk_wdata (cp_bk_wd),
        .bk_raddr (cp_bk_ra),
        .bk_rdata (bk_rdata)
    );

    dpmm_ram #(.WIDTH($bits(pte_t)), .DEPTH(PTE_DEPTH)) u_pte (
        .aclk  (aclk),
        .we    (pte_we),
        .waddr (pte_wa),
        .wdata (pte_wd),
        .raddr (pte_ra),
        .rdata (pte_rd)
    );

    dpmm_ram #(.WIDTH(16), .DEPTH(PHYS_DEPTH)) u_phys (
        .aclk  (aclk),
        .we    (ph_we),
        .waddr (ph_wa),
        .wdata (ph_wd),
        .raddr (ph_ra),
        .rdata (ph_rdata)
    );

    dpmm_ram #(.WIDTH(16), .DEPTH(BACK_DEPTH)) u_back (
        .aclk  (aclk),
        .we    (cp_bk_we),
        .waddr (cp_bk_wa),
        .wdata (cp_bk_wd),
        .raddr (cp_bk_ra),
        .rdata (bk_rdata)
    );

    // Drive the ports
    assign s_ready               = (state_reg == S_IDLE);
    assign m_valid               = (state_reg == S_OUT);
    assign m_read_word           = rword_reg;
    assign m_status              = stat_reg;
    assign m_fault_taken         = fault_reg;
    assign m_victim_written_back = wb_reg;
    assign m_frame_used          = (stat_reg == ST_OK && (op_reg == OP_READ ||
                                    op_reg == OP_WRITE)) ? 4'(fr_reg) : 4'd0;
    assign m_pages_granted       = 5'(gr_reg);
    assign m_paged_in_total      = pin_reg;
    assign m_paged_out_total     = pout_reg;

`ifndef SYNTH
    // The copy unit runs only in the copy states
    a_copy_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cp_busy |-> (state_reg == S_ZERO || state_reg == S_WBACK || state_reg == S_LOAD))
        else $error("copy running outside a copy state");
    // A write-back implies a page fault
    a_wb_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_victim_written_back) |-> m_fault_taken)
        else $error("write-back without fault");
    // Not ready while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("ready while result pending");
    // Page-in counter moves by at most one
    a_pin_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (pin_reg == $past(pin_reg) || pin_reg == $past(pin_reg) + 16'd1))
        else $error("page-in counter jumped");
`endif
endmodule
